@@ src/circular_list_engine_assert.svh @@
`ifndef CIRCULAR_LIST_ENGINE_ASSERT_SVH
`define CIRCULAR_LIST_ENGINE_ASSERT_SVH

// Checks in the same cycle; needs clk and arst_n in scope.
`define CLE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cle check failed");

// Checks in the following cycle.
`define CLE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cle check failed");

`endif

@@ src/cle_pkg.sv @@
package cle_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int CMD_W   = 2;
	localparam int POS_W   = 8;
	localparam int STAT_W  = 2;
	localparam int OCC_W   = 5;

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP     = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} mod_rsp_t;

	// (base + off) mod DEPTH, with off <= DEPTH
	function automatic logic [IDX_W-1:0] ring_idx(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

@@ src/cle_if.sv @@
interface cle_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [cle_pkg::CMD_W-1:0]         cmd;
	logic signed [cle_pkg::DATA_W-1:0] item_value;
	logic [cle_pkg::POS_W-1:0]         position;

	modport source (output valid, cmd, item_value, position, input ready);
	modport sink (input valid, cmd, item_value, position, output ready);
endinterface

interface cle_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [cle_pkg::DATA_W-1:0] read_value;
	logic                              last_item;
	logic [cle_pkg::STAT_W-1:0]        status;
	logic [cle_pkg::OCC_W-1:0]         occupancy;

	modport source (output valid, read_value, last_item, status, occupancy, input ready);
	modport sink (input valid, read_value, last_item, status, occupancy, output ready);
endinterface

@@ src/circular_list_engine.sv @@
// Circular list of up to DEPTH signed 32-bit values held in a single-port-write,
// registered-read RAM, one command at a time. Insert at head or tail writes the
// RAM on accept. Dump handles each element as a read, then a load of the result
// register; an empty list gives an empty status. Delete first finds the
// remainder of (position - 1) modulo the length (8-step serial unit), then moves
// up to DEPTH-2 elements down; each move is a RAM read followed by a write. Errors
// (full, empty, position 0) leave the list untouched. A pending result in the
// output register stalls only the next result, not the accept of the command.
module circular_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	cle_cmd_if.sink    req,
	cle_rsp_if.source  rsp
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_MOD       = 7'b0000010,
		ST_SHIFT_RD  = 7'b0000100,
		ST_SHIFT_WR  = 7'b0001000,
		ST_DUMP_RD   = 7'b0010000,
		ST_DUMP_WAIT = 7'b0100000,
		ST_EMIT      = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [cle_pkg::IDX_W-1:0]       head_q;
	logic [cle_pkg::CNT_W-1:0]       count_q;
	logic [cle_pkg::CNT_W-1:0]       idx_q;
	logic [cle_pkg::STAT_W-1:0]      status_q;

	logic                            rsp_valid_q;
	logic [cle_pkg::DATA_W-1:0]      rsp_value_q;
	logic                            rsp_last_q;
	logic [cle_pkg::STAT_W-1:0]      rsp_status_q;
	logic [cle_pkg::OCC_W-1:0]       rsp_occ_q;

	logic                            accept;
	logic                            out_free;
	logic                            full;
	logic                            empty;
	logic                            dump_last;
	logic                            load_emit;
	logic                            load_dump;
	logic [cle_pkg::IDX_W-1:0]       head_dec;

	logic                            ram_we;
	logic [cle_pkg::IDX_W-1:0]       ram_waddr;
	logic [cle_pkg::DATA_W-1:0]      ram_wdata;
	logic                            ram_re;
	logic [cle_pkg::IDX_W-1:0]       ram_raddr;
	logic [cle_pkg::DATA_W-1:0]      ram_rdata;

	cle_pkg::mod_req_t               mod_req;
	cle_pkg::mod_rsp_t               mod_rsp;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign full      = (count_q == cle_pkg::CNT_W'(cle_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign dump_last = (cle_pkg::CNT_W'(idx_q + 1'b1) == count_q);
	assign load_emit = (state_q == ST_EMIT) && out_free;
	assign load_dump = (state_q == ST_DUMP_WAIT) && out_free;
	assign head_dec  = (head_q == '0) ? cle_pkg::IDX_W'(cle_pkg::DEPTH - 1) : head_q - 1'b1;

	assign mod_req.start    = accept && (req.cmd == cle_pkg::CMD_DELETE) && !empty
	                          && (req.position != '0);
	assign mod_req.dividend = req.position - 1'b1;
	assign mod_req.divisor  = count_q;

	// storage port control; a move reads the upper entry, then writes the lower one
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_dec;
		ram_wdata = req.item_value;
		ram_re    = 1'b0;
		ram_raddr = cle_pkg::ring_idx(head_q, idx_q);
		if (accept && !full) begin
			if (req.cmd == cle_pkg::CMD_INS_HEAD) begin
				ram_we = 1'b1;
			end else if (req.cmd == cle_pkg::CMD_INS_TAIL) begin
				ram_we    = 1'b1;
				ram_waddr = cle_pkg::ring_idx(head_q, count_q);
			end
		end
		if (state_q == ST_SHIFT_RD) begin
			ram_re    = 1'b1;
			ram_raddr = cle_pkg::ring_idx(head_q, cle_pkg::CNT_W'(idx_q + 1'b1));
		end
		if (state_q == ST_SHIFT_WR) begin
			ram_we    = 1'b1;
			ram_waddr = cle_pkg::ring_idx(head_q, idx_q);
			ram_wdata = ram_rdata;
		end
		if (state_q == ST_DUMP_RD) begin
			ram_re = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= cle_pkg::STAT_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							cle_pkg::CMD_INS_HEAD: begin
								state_q <= ST_EMIT;
								if (full) begin
									status_q <= cle_pkg::STAT_FULL;
								end else begin
									status_q <= cle_pkg::STAT_OK;
									head_q   <= head_dec;
									count_q  <= count_q + 1'b1;
								end
							end
							cle_pkg::CMD_INS_TAIL: begin
								state_q <= ST_EMIT;
								if (full) begin
									status_q <= cle_pkg::STAT_FULL;
								end else begin
									status_q <= cle_pkg::STAT_OK;
									count_q  <= count_q + 1'b1;
								end
							end
							cle_pkg::CMD_DELETE: begin
								if (empty) begin
									status_q <= cle_pkg::STAT_EMPTY;
									state_q  <= ST_EMIT;
								end else if (req.position == '0) begin
									status_q <= cle_pkg::STAT_BADPOS;
									state_q  <= ST_EMIT;
								end else begin
									state_q <= ST_MOD;
								end
							end
							cle_pkg::CMD_DUMP: begin
								if (empty) begin
									status_q <= cle_pkg::STAT_EMPTY;
									state_q  <= ST_EMIT;
								end else begin
									idx_q   <= '0;
									state_q <= ST_DUMP_RD;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MOD: begin
					if (mod_rsp.done) begin
						status_q <= cle_pkg::STAT_OK;
						if (mod_rsp.rem == '0) begin
							head_q  <= cle_pkg::ring_idx(head_q, cle_pkg::CNT_W'(1));
							count_q <= count_q - 1'b1;
							state_q <= ST_EMIT;
						end else if (cle_pkg::CNT_W'(mod_rsp.rem + 1'b1) < count_q) begin
							idx_q   <= mod_rsp.rem;
							state_q <= ST_SHIFT_RD;
						end else begin
							count_q <= count_q - 1'b1;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					idx_q <= idx_q + 1'b1;
					if (cle_pkg::CNT_W'(idx_q + 2'd2) < count_q) begin
						state_q <= ST_SHIFT_RD;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_WAIT;
				end
				ST_DUMP_WAIT: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_DUMP_RD;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_emit || load_dump) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_emit) begin
			rsp_value_q  <= '0;
			rsp_last_q   <= 1'b1;
			rsp_status_q <= status_q;
			rsp_occ_q    <= cle_pkg::OCC_W'(count_q);
		end else if (load_dump) begin
			rsp_value_q  <= ram_rdata;
			rsp_last_q   <= dump_last;
			rsp_status_q <= cle_pkg::STAT_OK;
			rsp_occ_q    <= cle_pkg::OCC_W'(count_q);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rsp_value_q;
	assign rsp.last_item  = rsp_last_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.occupancy  = rsp_occ_q;

	cle_ram #(
		.DEPTH (cle_pkg::DEPTH),
		.WIDTH (cle_pkg::DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cle_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

endmodule

@@ src/cle_ram.sv @@
module cle_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/cle_mod.sv @@
module cle_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  cle_pkg::mod_req_t req,
	output cle_pkg::mod_rsp_t rsp
);

	localparam int STEP_W = $clog2(cle_pkg::POS_W);

	logic                           busy_q;
	logic                           done_q;
	logic [STEP_W-1:0]              step_q;
	logic [cle_pkg::POS_W-1:0]      dvd_q;
	logic [cle_pkg::CNT_W-1:0]      div_q;
	logic [cle_pkg::CNT_W-1:0]      rem_q;
	logic [cle_pkg::CNT_W:0]        trial;
	logic [cle_pkg::CNT_W:0]        rem_nxt;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, dvd_q[cle_pkg::POS_W-1]};
		if (trial >= (cle_pkg::CNT_W+1)'(div_q)) begin
			rem_nxt = trial - (cle_pkg::CNT_W+1)'(div_q);
		end else begin
			rem_nxt = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(cle_pkg::POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[cle_pkg::POS_W-2:0], 1'b0};
			rem_q <= rem_nxt[cle_pkg::CNT_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ src/cle_checker.sv @@
`include "circular_list_engine_assert.svh"

module cle_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [cle_pkg::DATA_W-1:0] rsp_read_value,
	input logic                              rsp_last_item,
	input logic [cle_pkg::STAT_W-1:0]        rsp_status,
	input logic [cle_pkg::OCC_W-1:0]         rsp_occupancy
);

	`CLE_ASSERT_SAME(a_occ_range, rsp_valid, rsp_occupancy <= cle_pkg::OCC_W'(cle_pkg::DEPTH))
	`CLE_ASSERT_SAME(a_full_occ, rsp_valid && (rsp_status == cle_pkg::STAT_FULL), rsp_occupancy == cle_pkg::OCC_W'(cle_pkg::DEPTH))
	`CLE_ASSERT_SAME(a_empty_beat, rsp_valid && (rsp_status == cle_pkg::STAT_EMPTY), (rsp_occupancy == '0) && rsp_last_item && (rsp_read_value == '0))
	`CLE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
	`CLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_value) && $stable(rsp_last_item))

endmodule

bind circular_list_engine cle_checker u_cle_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_last_item  (rsp.last_item),
	.rsp_status     (rsp.status),
	.rsp_occupancy  (rsp.occupancy)
);
